// File: rtl/wheel_encoder_odometry_assert.svh
// Assertion macros shared by the checker of the wheel encoder odometry block.
// No dependencies beyond a SystemVerilog simulator with concurrent assertions.
`ifndef WHEEL_ENCODER_ODOMETRY_ASSERT_SVH
`define WHEEL_ENCODER_ODOMETRY_ASSERT_SVH

// Implication checked in the same cycle, disabled during reset.
`define WEO_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("weo assertion failed");

// Implication checked in the following cycle, disabled during reset.
`define WEO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("weo assertion failed");

// Implication checked in the following cycle, active through reset.
`define WEO_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("weo assertion failed");

`endif

// File: rtl/weo_pkg.sv
// Package of the wheel encoder odometry block: field widths, request codes,
// register indexes, reset values and arithmetic constants. No dependencies.
package weo_pkg;

    localparam int unsigned CIRC_W = 20;
    localparam int unsigned PPR_W  = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned POS_W  = 52;
    localparam int unsigned RPM_W  = 34;
    localparam int unsigned VEL_W  = 42;
    localparam int unsigned DUTY_W = 8;
    localparam int unsigned DEN_W  = 48;
    localparam int unsigned CV_W   = 40;
    localparam int unsigned CFG_W  = 32;

    localparam logic [1:0] REQ_PULSE   = 2'd0;
    localparam logic [1:0] REQ_STATUS  = 2'd1;
    localparam logic [1:0] REQ_COMMAND = 2'd2;
    localparam logic [1:0] REQ_REFRESH = 2'd3;

    localparam logic [1:0] CFG_CIRC    = 2'd0;
    localparam logic [1:0] CFG_PPR     = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [CIRC_W-1:0] CIRC_RESET    = 20'd628318;
    localparam logic [PPR_W-1:0]  PPR_RESET     = 16'd1;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000000;

    localparam logic [RPM_W-1:0] RPM_NUM  = 34'd15360000000;
    localparam logic [RPM_W-1:0] RPM_MAX  = {RPM_W{1'b1}};
    localparam logic [VEL_W-1:0] VEL_MAX  = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [CV_W-1:0]  US_PER_S = 40'd1000000;

endpackage

// File: rtl/weo_if.sv
// Valid/ready channel interfaces of the wheel encoder odometry block.
// Depends on weo_pkg for the field widths.
interface weo_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic [weo_pkg::TIME_W-1:0]  now_us;
    logic [weo_pkg::DUTY_W-1:0]  speed;
    logic                        forward;

    modport source (output valid, req_type, now_us, speed, forward, input ready);
    modport sink   (input valid, req_type, now_us, speed, forward, output ready);
endinterface

interface weo_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [weo_pkg::POS_W-1:0]  position_um;
    logic [weo_pkg::RPM_W-1:0]         rpm_q8;
    logic signed [weo_pkg::VEL_W-1:0]  velocity_um_s;
    logic                              rate_saturated;
    logic                              timed_out;
    logic                              direction_pin;
    logic                              brake_pin;
    logic [weo_pkg::DUTY_W-1:0]        pwm_duty;

    modport source (output valid, position_um, rpm_q8, velocity_um_s, rate_saturated,
                    timed_out, direction_pin, brake_pin, pwm_duty, input ready);
    modport sink   (input valid, position_um, rpm_q8, velocity_um_s, rate_saturated,
                    timed_out, direction_pin, brake_pin, pwm_duty, output ready);
endinterface

// File: rtl/wheel_encoder_odometry.sv
// Wheel encoder odometry: pulse count, position, rpm, velocity and motor command.
// A status read, command or refresh gives its result in the cycle after its transfer.
// A pulse runs a bit-serial multiply, then 52-step restoring divisions
// (position, then rpm and velocity when the interval is nonzero).
// Synchronous active-low reset restores config and clears control and odometry state.
// Depends on weo_pkg and the interfaces in weo_if.
module wheel_encoder_odometry (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [weo_pkg::CFG_W-1:0]   i_cfg_data,
    weo_in_if.sink                      i_in,
    weo_out_if.source                   o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    localparam logic [1:0] PH_POS = 2'd0;
    localparam logic [1:0] PH_RPM = 2'd1;
    localparam logic [1:0] PH_VEL = 2'd2;

    localparam int unsigned CNT_W    = 6;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(weo_pkg::TIME_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(weo_pkg::POS_W - 1);

    logic [2:0]                      r_state;
    logic [1:0]                      r_phase;
    logic [CNT_W-1:0]                r_cnt;

    logic [weo_pkg::CIRC_W-1:0]      r_circ;
    logic [weo_pkg::PPR_W-1:0]       r_ppr;
    logic [weo_pkg::TIME_W-1:0]      r_timeout;

    logic [weo_pkg::TIME_W-1:0]      r_count;
    logic [weo_pkg::TIME_W-1:0]      r_last;
    logic                            r_first;
    logic [weo_pkg::POS_W-1:0]       r_pos;
    logic [weo_pkg::RPM_W-1:0]       r_rpm;
    logic [weo_pkg::VEL_W-1:0]       r_vel;
    logic                            r_sat;
    logic                            r_rev;
    logic [weo_pkg::TIME_W-1:0]      r_wd;
    logic [weo_pkg::DUTY_W-1:0]      r_duty;

    logic [weo_pkg::TIME_W-1:0]      r_now;
    logic                            r_dt_zero;
    logic                            r_neg;
    logic [weo_pkg::TIME_W-1:0]      r_mplr_a;
    logic [weo_pkg::POS_W-1:0]       r_mcnd_a;
    logic [weo_pkg::POS_W-1:0]       r_acc_a;
    logic [weo_pkg::PPR_W-1:0]       r_mplr_b;
    logic [weo_pkg::DEN_W-1:0]       r_mcnd_b;
    logic [weo_pkg::DEN_W-1:0]       r_acc_b;
    logic [weo_pkg::CIRC_W-1:0]      r_mplr_c;
    logic [weo_pkg::CV_W-1:0]        r_mcnd_c;
    logic [weo_pkg::CV_W-1:0]        r_acc_c;

    logic [weo_pkg::POS_W-1:0]       r_dvd;
    logic [weo_pkg::DEN_W-1:0]       r_rem;
    logic [weo_pkg::POS_W-1:0]       r_quo;
    logic [weo_pkg::DEN_W-1:0]       r_dvs;

    logic                            r_ovalid;
    logic [weo_pkg::POS_W-1:0]       r_o_pos;
    logic [weo_pkg::RPM_W-1:0]       r_o_rpm;
    logic [weo_pkg::VEL_W-1:0]       r_o_vel;
    logic                            r_o_sat;
    logic                            r_o_to;
    logic                            r_o_dir;
    logic                            r_o_brake;
    logic [weo_pkg::DUTY_W-1:0]      r_o_duty;

    logic                            w_out_free;
    logic                            w_in_xfer;
    logic [weo_pkg::PPR_W-1:0]       w_ppr_eff;
    logic [weo_pkg::TIME_W-1:0]      n_count;
    logic [weo_pkg::TIME_W-1:0]      w_dt;
    logic [weo_pkg::TIME_W-1:0]      w_mag;
    logic                            n_rev;
    logic [weo_pkg::DUTY_W-1:0]      n_duty;
    logic [weo_pkg::TIME_W-1:0]      n_wd;
    logic [weo_pkg::DEN_W:0]         w_trial;
    logic [weo_pkg::DEN_W:0]         w_diff;
    logic [weo_pkg::POS_W-1:0]       w_quo;
    logic [weo_pkg::POS_W-1:0]       w_pos_sgn;
    logic [weo_pkg::VEL_W-1:0]       w_vel_q;

    assign w_out_free = !r_ovalid || o_res.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_ppr_eff  = (r_ppr == '0) ? weo_pkg::PPR_W'(1) : r_ppr;

    always_comb begin
        if (r_rev) begin
            n_count = (r_count == 32'h8000_0000) ? '0 : r_count - 32'd1;
        end else begin
            n_count = (r_count == 32'h7FFF_FFFF) ? '0 : r_count + 32'd1;
        end
        w_mag = n_count[31] ? (32'd0 - n_count) : n_count;
        w_dt  = r_first ? (i_in.now_us - r_last) : '0;
        n_rev  = r_rev;
        n_duty = r_duty;
        n_wd   = r_wd;
        case (i_in.req_type)
            weo_pkg::REQ_COMMAND: begin
                n_rev  = !i_in.forward;
                n_duty = i_in.speed;
            end
            weo_pkg::REQ_REFRESH: begin
                n_wd = i_in.now_us;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_trial   = {r_rem, r_dvd[weo_pkg::POS_W-1]};
        w_diff    = w_trial - {1'b0, r_dvs};
        w_quo     = {r_quo[weo_pkg::POS_W-2:0], !w_diff[weo_pkg::DEN_W]};
        w_pos_sgn = r_neg ? ('0 - w_quo) : w_quo;
        w_vel_q   = r_rev ? ('0 - w_quo[weo_pkg::VEL_W-1:0]) : w_quo[weo_pkg::VEL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_POS;
            r_cnt     <= '0;
            r_circ    <= weo_pkg::CIRC_RESET;
            r_ppr     <= weo_pkg::PPR_RESET;
            r_timeout <= weo_pkg::TIMEOUT_RESET;
            r_count   <= '0;
            r_last    <= '0;
            r_first   <= 1'b0;
            r_pos     <= '0;
            r_rpm     <= '0;
            r_vel     <= '0;
            r_sat     <= 1'b0;
            r_rev     <= 1'b0;
            r_wd      <= '0;
            r_duty    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    weo_pkg::CFG_CIRC:    r_circ    <= i_cfg_data[weo_pkg::CIRC_W-1:0];
                    weo_pkg::CFG_PPR:     r_ppr     <= i_cfg_data[weo_pkg::PPR_W-1:0];
                    weo_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[weo_pkg::TIME_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_ovalid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        if (i_in.req_type == weo_pkg::REQ_PULSE) begin
                            r_count   <= n_count;
                            r_first   <= 1'b1;
                            r_last    <= i_in.now_us;
                            r_now     <= i_in.now_us;
                            r_dt_zero <= (w_dt == '0);
                            r_neg     <= n_count[31];
                            r_mplr_a  <= w_mag;
                            r_mcnd_a  <= weo_pkg::POS_W'(r_circ);
                            r_acc_a   <= '0;
                            r_mplr_b  <= w_ppr_eff;
                            r_mcnd_b  <= weo_pkg::DEN_W'(w_dt);
                            r_acc_b   <= '0;
                            r_mplr_c  <= r_circ;
                            r_mcnd_c  <= weo_pkg::US_PER_S;
                            r_acc_c   <= '0;
                            r_cnt     <= '0;
                            r_state   <= S_MUL;
                        end else begin
                            r_rev     <= n_rev;
                            r_duty    <= n_duty;
                            r_wd      <= n_wd;
                            if (i_in.req_type == weo_pkg::REQ_STATUS) begin
                                r_rpm <= '0;
                                r_vel <= '0;
                            end
                            r_ovalid  <= 1'b1;
                            r_o_pos   <= r_pos;
                            r_o_rpm   <= r_rpm;
                            r_o_vel   <= r_vel;
                            r_o_sat   <= r_sat;
                            r_o_to    <= ((i_in.now_us - n_wd) >= r_timeout);
                            r_o_dir   <= !n_rev;
                            r_o_brake <= (n_duty == '0);
                            r_o_duty  <= n_duty;
                        end
                    end
                end
                S_MUL: begin
                    if (r_mplr_a[0]) r_acc_a <= r_acc_a + r_mcnd_a;
                    if (r_mplr_b[0]) r_acc_b <= r_acc_b + r_mcnd_b;
                    if (r_mplr_c[0]) r_acc_c <= r_acc_c + r_mcnd_c;
                    r_mplr_a <= r_mplr_a >> 1;
                    r_mplr_b <= r_mplr_b >> 1;
                    r_mplr_c <= r_mplr_c >> 1;
                    r_mcnd_a <= r_mcnd_a << 1;
                    r_mcnd_b <= r_mcnd_b << 1;
                    r_mcnd_c <= r_mcnd_c << 1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) begin
                        r_dvd   <= r_mplr_a[0] ? r_acc_a + r_mcnd_a : r_acc_a;
                        r_dvs   <= weo_pkg::DEN_W'(w_ppr_eff);
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_phase <= PH_POS;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dvd <= r_dvd << 1;
                    r_quo <= w_quo;
                    r_rem <= w_diff[weo_pkg::DEN_W] ? w_trial[weo_pkg::DEN_W-1:0]
                                                     : w_diff[weo_pkg::DEN_W-1:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_quo <= '0;
                        case (r_phase)
                            PH_POS: begin
                                r_pos <= w_pos_sgn;
                                if (r_dt_zero) begin
                                    r_sat   <= 1'b1;
                                    r_rpm   <= weo_pkg::RPM_MAX;
                                    r_vel   <= r_rev ? ('0 - weo_pkg::VEL_MAX)
                                                     : weo_pkg::VEL_MAX;
                                    r_state <= S_OUT;
                                end else begin
                                    r_sat   <= 1'b0;
                                    r_dvd   <= weo_pkg::POS_W'(weo_pkg::RPM_NUM);
                                    r_dvs   <= r_acc_b;
                                    r_phase <= PH_RPM;
                                end
                            end
                            PH_RPM: begin
                                r_rpm   <= w_quo[weo_pkg::RPM_W-1:0];
                                r_dvd   <= weo_pkg::POS_W'(r_acc_c);
                                r_phase <= PH_VEL;
                            end
                            default: begin
                                r_vel   <= w_vel_q;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid  <= 1'b1;
                        r_o_pos   <= r_pos;
                        r_o_rpm   <= r_rpm;
                        r_o_vel   <= r_vel;
                        r_o_sat   <= r_sat;
                        r_o_to    <= ((r_now - r_wd) >= r_timeout);
                        r_o_dir   <= !r_rev;
                        r_o_brake <= (r_duty == '0);
                        r_o_duty  <= r_duty;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid          = r_ovalid;
    assign o_res.position_um    = r_o_pos;
    assign o_res.rpm_q8         = r_o_rpm;
    assign o_res.velocity_um_s  = r_o_vel;
    assign o_res.rate_saturated = r_o_sat;
    assign o_res.timed_out      = r_o_to;
    assign o_res.direction_pin  = r_o_dir;
    assign o_res.brake_pin      = r_o_brake;
    assign o_res.pwm_duty       = r_o_duty;

endmodule

// File: rtl/weo_checker.sv
// Port-level checker of the wheel encoder odometry block and its bind statement.
// Depends on weo_pkg, wheel_encoder_odometry_assert.svh and the top level.
`include "wheel_encoder_odometry_assert.svh"

module weo_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [weo_pkg::POS_W-1:0]   i_position_um,
    input  logic                        i_brake_pin,
    input  logic [weo_pkg::DUTY_W-1:0]  i_pwm_duty
);

    `WEO_ASSERT_NOW(a_brake_duty, i_clk, i_rst_n, i_out_valid, i_brake_pin == (i_pwm_duty == '0))
    `WEO_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)
    `WEO_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `WEO_ASSERT_NEXT(a_hold_pos, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_position_um))

endmodule

bind wheel_encoder_odometry weo_checker u_weo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_position_um (o_res.position_um),
    .i_brake_pin   (o_res.brake_pin),
    .i_pwm_duty    (o_res.pwm_duty)
);
